/* rtl/core/fstat_pkg.sv */
// fstat_pkg: shared types and constants of the frame statistics monitor
// used by every module under rtl/core, depends on nothing
package fstat_pkg;

   // field widths
   localparam int ID_W           = 32;
   localparam int STAMP_W        = 48;
   localparam int BYTES_W        = 26;
   localparam int TIME_W         = 40;
   localparam int OUT_W          = 32;
   localparam int BYTE_TOTAL_W   = 48;

   // counter width default
   localparam int DEF_COUNT_BITS = 32;

   // scale constants: frames/s x100 from microseconds, Mbit/s x100 from bytes
   localparam int SCALE_W = 27;
   localparam logic [SCALE_W-1:0] RATE_SCALE = 27'd100000000;
   localparam logic [SCALE_W-1:0] BITS_SCALE = 27'd800;

   // command queue depth between front and back
   localparam int CMD_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_INCOMPLETE,
      CMD_FRAME
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [ID_W-1:0]       id;
      logic [STAMP_W-1:0]    stamp;
      logic [BYTES_W-1:0]    bytes;
      logic [TIME_W-1:0]     now;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic start;
      logic use_bits_scale;
   } ratio_ctl_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_RATE,
      B_RATE_WAIT,
      B_TPUT,
      B_TPUT_WAIT,
      B_EMIT
   } back_state_type;

   typedef enum logic [1:0] {
      R_IDLE,
      R_MUL,
      R_CHECK,
      R_DIV
   } ratio_state_type;

endpackage

/* rtl/core/frame_statistics_monitor.sv */
// frame_statistics_monitor: top level of the frame statistics monitor
// depends on fstat_pkg, fstat_front, fstat_cmd_fifo, fstat_ratio, fstat_back
//
// Usage:
//   Input side is a queue: drive the fields and push; the transaction is
//   taken on a clock edge with push high and full low. req_type low clears
//   all statistics, high reports one frame (req_frame_incomplete marks a
//   partial frame). Result side is a queue too: while empty is low the
//   statistics after the oldest transaction are on the rsp_ ports, and pop
//   takes them. Every input transaction yields exactly one result.
//   csr_wr_en writes csr_wr_data into the averaging-mode bit; write it only
//   while no transaction is in flight.
// Clears, incomplete frames and the first complete frame pass the input
// stage, the command queue and the emit step before empty goes low. Later
// complete frames make two passes through the ratio unit, each ceil(W/32)
// multiply steps, a range check and 32 divide steps (W = wider of
// COUNT_BITS and 48), fewer on saturation. The back takes no command while
// one is in progress or a result is still unpopped.
// Reset (synchronous, active high) clears all statistics, the mode bit and
// both queues. An unpopped result is held, three more transactions wait
// behind it (two queued, one in the input stage), and then full rises.
module frame_statistics_monitor
   import fstat_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic                 req_type,
   input  logic                 req_frame_incomplete,
   input  logic [ID_W-1:0]      req_frame_id,
   input  logic [STAMP_W-1:0]   req_frame_timestamp,
   input  logic [BYTES_W-1:0]   req_bytes_filled,
   input  logic [TIME_W-1:0]    req_now_us,
   output logic                 empty,
   input  logic                 pop,
   output logic [OUT_W-1:0]     rsp_frames_total,
   output logic [OUT_W-1:0]     rsp_frames_incomplete,
   output logic [OUT_W-1:0]     rsp_frames_dropped,
   output logic [ID_W-1:0]      rsp_last_id,
   output logic [STAMP_W-1:0]   rsp_last_stamp,
   output logic [OUT_W-1:0]     rsp_rate_x100,
   output logic [OUT_W-1:0]     rsp_throughput_x100,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data
);

   localparam int OPW = (COUNT_BITS > BYTE_TOTAL_W) ? COUNT_BITS : BYTE_TOTAL_W;

   logic             average_mode_ff, average_mode_in;
   logic             fifo_push;
   cmd_type          fifo_wr_data;
   cmd_type          fifo_rd_data;
   fifo_status_type  fifo_status;
   logic             fifo_pop;
   ratio_ctl_type    ratio_ctl;
   logic [OPW-1:0]   ratio_operand;
   logic [TIME_W-1:0] ratio_den;
   logic             ratio_done;
   logic [OUT_W-1:0] ratio_quo;

   // mode register
   assign average_mode_in = csr_wr_en ? csr_wr_data : average_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         average_mode_ff <= 1'b0;
      end else begin
         average_mode_ff <= average_mode_in;
      end
   end

   // front: accept and classify
   fstat_front u_front (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_type             (req_type),
      .req_frame_incomplete (req_frame_incomplete),
      .req_frame_id         (req_frame_id),
      .req_frame_timestamp  (req_frame_timestamp),
      .req_bytes_filled     (req_bytes_filled),
      .req_now_us           (req_now_us),
      .fifo_push            (fifo_push),
      .fifo_data            (fifo_wr_data),
      .fifo_status          (fifo_status)
   );

   // command queue between front and back
   fstat_cmd_fifo u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_push (fifo_push),
      .wr_data (fifo_wr_data),
      .rd_pop  (fifo_pop),
      .rd_data (fifo_rd_data),
      .status  (fifo_status)
   );

   // shared scale-and-divide unit
   fstat_ratio #(
      .COUNT_BITS (COUNT_BITS)
   ) u_ratio (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ratio_ctl),
      .operand (ratio_operand),
      .den     (ratio_den),
      .done    (ratio_done),
      .quo     (ratio_quo)
   );

   // back: statistics update and result register
   fstat_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .average_mode          (average_mode_ff),
      .cmd_data              (fifo_rd_data),
      .cmd_status            (fifo_status),
      .cmd_pop               (fifo_pop),
      .ratio_ctl             (ratio_ctl),
      .ratio_operand         (ratio_operand),
      .ratio_den             (ratio_den),
      .ratio_done            (ratio_done),
      .ratio_quo             (ratio_quo),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_frames_total      (rsp_frames_total),
      .rsp_frames_incomplete (rsp_frames_incomplete),
      .rsp_frames_dropped    (rsp_frames_dropped),
      .rsp_last_id           (rsp_last_id),
      .rsp_last_stamp        (rsp_last_stamp),
      .rsp_rate_x100         (rsp_rate_x100),
      .rsp_throughput_x100   (rsp_throughput_x100)
   );

endmodule

/* rtl/core/fstat_front.sv */
// fstat_front: input stage, classifies each transaction into a command
// depends on fstat_pkg, feeds fstat_cmd_fifo
module fstat_front
   import fstat_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic                 req_type,
   input  logic                 req_frame_incomplete,
   input  logic [ID_W-1:0]      req_frame_id,
   input  logic [STAMP_W-1:0]   req_frame_timestamp,
   input  logic [BYTES_W-1:0]   req_bytes_filled,
   input  logic [TIME_W-1:0]    req_now_us,
   output logic                 fifo_push,
   output cmd_type              fifo_data,
   input  fifo_status_type      fifo_status
);

   logic    stage_valid_ff, stage_valid_in;
   cmd_type stage_ff, stage_in;
   cmd_type decoded;
   logic    accept;

   // classify the incoming transaction
   always_comb begin
      if (!req_type) begin
         decoded.kind = CMD_CLEAR;
      end else if (req_frame_incomplete) begin
         decoded.kind = CMD_INCOMPLETE;
      end else begin
         decoded.kind = CMD_FRAME;
      end
      decoded.id    = req_frame_id;
      decoded.stamp = req_frame_timestamp;
      decoded.bytes = req_bytes_filled;
      decoded.now   = req_now_us;
   end

   // stage moves into the queue whenever the queue has room
   assign full      = stage_valid_ff & fifo_status.full;
   assign accept    = push & ~full;
   assign fifo_push = stage_valid_ff & ~fifo_status.full;
   assign fifo_data = stage_ff;

   always_comb begin
      stage_valid_in = accept | (stage_valid_ff & fifo_status.full);
      stage_in       = accept ? decoded : stage_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

endmodule

/* rtl/core/fstat_cmd_fifo.sv */
// fstat_cmd_fifo: short command queue between front and back
// depends on fstat_pkg
module fstat_cmd_fifo
   import fstat_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_push,
   input  cmd_type         wr_data,
   input  logic            rd_pop,
   output cmd_type         rd_data,
   output fifo_status_type status
);

   localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type            slot_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign status.full  = (count_ff == CNT_W'(CMD_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_wr        = wr_push & ~status.full;
   assign do_rd        = rd_pop & ~status.empty;
   assign rd_data      = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/core/fstat_ratio.sv */
// fstat_ratio: operand times scale constant, divided by an interval
// chunked multiply then 32-step restoring divide, saturating; uses fstat_pkg
module fstat_ratio
   import fstat_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  ratio_ctl_type        ctl,
   input  logic [((COUNT_BITS > BYTE_TOTAL_W) ? COUNT_BITS : BYTE_TOTAL_W)-1:0] operand,
   input  logic [TIME_W-1:0]    den,
   output logic                 done,
   output logic [OUT_W-1:0]     quo
);

   localparam int OPW   = (COUNT_BITS > BYTE_TOTAL_W) ? COUNT_BITS : BYTE_TOTAL_W;
   localparam int CH    = (OPW + 31) / 32;
   localparam int CHW   = (CH > 1) ? $clog2(CH) : 1;
   localparam int NUM_W = (COUNT_BITS + SCALE_W > BYTE_TOTAL_W + 10) ?
                          COUNT_BITS + SCALE_W : BYTE_TOTAL_W + 10;
   localparam int HI_W  = NUM_W - 32;
   localparam int CMP_W = (HI_W > TIME_W) ? HI_W : TIME_W;
   localparam int PROD_W = 32 + SCALE_W;

   ratio_state_type     state_ff, state_in;
   logic [CH*32-1:0]    op_ff, op_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [31:0]         lo_ff, lo_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [CHW-1:0]      chunk_ff, chunk_in;
   logic                done_ff, done_in;
   logic [OUT_W-1:0]    quo_ff, quo_in;
   logic [PROD_W-1:0]   prod;
   logic [HI_W-1:0]     num_hi;
   logic [TIME_W:0]     trial;
   logic                trial_ge;

   // one 32-bit chunk of the operand times the scale constant
   assign prod     = PROD_W'(op_ff[CH*32-1 -: 32]) * PROD_W'(scale_ff);
   assign num_hi   = num_ff[NUM_W-1:32];
   assign trial    = {rem_ff, lo_ff[31]};
   assign trial_ge = (trial >= {1'b0, den});

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      scale_in = scale_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      chunk_in = chunk_ff;
      done_in  = 1'b0;
      quo_in   = quo_ff;
      case (state_ff)
         R_IDLE: begin
            if (ctl.start) begin
               op_in    = (CH*32)'(operand);
               scale_in = ctl.use_bits_scale ? BITS_SCALE : RATE_SCALE;
               num_in   = '0;
               chunk_in = CHW'(CH - 1);
               state_in = R_MUL;
            end
         end
         // accumulate most significant chunk first
         R_MUL: begin
            num_in   = NUM_W'({num_ff, 32'b0}) + NUM_W'(prod);
            op_in    = op_ff << 32;
            chunk_in = chunk_ff - 1'b1;
            if (chunk_ff == '0) begin
               state_in = R_CHECK;
            end
         end
         // quotient needs more than 32 bits, or zero interval: saturate
         R_CHECK: begin
            if (CMP_W'(num_hi) >= CMP_W'(den)) begin
               quo_in   = '1;
               done_in  = 1'b1;
               state_in = R_IDLE;
            end else begin
               rem_in   = TIME_W'(num_hi);
               lo_in    = num_ff[31:0];
               cnt_in   = 5'd31;
               state_in = R_DIV;
            end
         end
         // one quotient bit per cycle
         R_DIV: begin
            rem_in = trial_ge ? TIME_W'(trial - {1'b0, den}) : trial[TIME_W-1:0];
            lo_in  = {lo_ff[30:0], trial_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               quo_in   = {lo_ff[30:0], trial_ge};
               done_in  = 1'b1;
               state_in = R_IDLE;
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff    <= op_in;
      scale_ff <= scale_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      lo_ff    <= lo_in;
      cnt_ff   <= cnt_in;
      chunk_ff <= chunk_in;
      quo_ff   <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

/* rtl/core/fstat_back.sv */
// fstat_back: statistics state, command execution and result register
// depends on fstat_pkg, drives one fstat_ratio unit
module fstat_back
   import fstat_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    average_mode,
   input  cmd_type                 cmd_data,
   input  fifo_status_type         cmd_status,
   output logic                    cmd_pop,
   output ratio_ctl_type           ratio_ctl,
   output logic [((COUNT_BITS > BYTE_TOTAL_W) ? COUNT_BITS : BYTE_TOTAL_W)-1:0] ratio_operand,
   output logic [TIME_W-1:0]       ratio_den,
   input  logic                    ratio_done,
   input  logic [OUT_W-1:0]        ratio_quo,
   output logic                    empty,
   input  logic                    pop,
   output logic [OUT_W-1:0]        rsp_frames_total,
   output logic [OUT_W-1:0]        rsp_frames_incomplete,
   output logic [OUT_W-1:0]        rsp_frames_dropped,
   output logic [ID_W-1:0]         rsp_last_id,
   output logic [STAMP_W-1:0]      rsp_last_stamp,
   output logic [OUT_W-1:0]        rsp_rate_x100,
   output logic [OUT_W-1:0]        rsp_throughput_x100
);

   localparam int OPW   = (COUNT_BITS > BYTE_TOTAL_W) ? COUNT_BITS : BYTE_TOTAL_W;
   localparam int SUM_W = ((COUNT_BITS > ID_W) ? COUNT_BITS : ID_W) + 1;

   back_state_type           state_ff, state_in;
   logic [COUNT_BITS-1:0]    total_ff, total_in;
   logic [COUNT_BITS-1:0]    incomp_ff, incomp_in;
   logic [COUNT_BITS-1:0]    drop_ff, drop_in;
   logic [ID_W-1:0]          prev_id_ff, prev_id_in;
   logic [STAMP_W-1:0]       stamp_ff, stamp_in;
   logic [OUT_W-1:0]         rate_ff, rate_in;
   logic [OUT_W-1:0]         tput_ff, tput_in;
   logic [TIME_W-1:0]        first_time_ff, first_time_in;
   logic [TIME_W-1:0]        prev_time_ff, prev_time_in;
   logic [BYTE_TOTAL_W-1:0]  byte_total_ff, byte_total_in;
   logic                     seen_first_ff, seen_first_in;
   logic [TIME_W-1:0]        dt_ff, dt_in;
   logic [BYTES_W-1:0]       cur_bytes_ff, cur_bytes_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [OUT_W-1:0]         rsp_total_ff, rsp_incomp_ff, rsp_drop_ff;
   logic [ID_W-1:0]          rsp_id_ff;
   logic [STAMP_W-1:0]       rsp_stamp_ff;
   logic [OUT_W-1:0]         rsp_rate_ff, rsp_tput_ff;

   logic [ID_W-1:0]          gap;
   logic [SUM_W-1:0]         drop_sum;
   logic [BYTE_TOTAL_W:0]    byte_sum;
   logic                     take;

   // dropped frames: ID gap after a nonzero previous ID, saturating add
   assign gap      = (prev_id_ff != '0 && cmd_data.id > prev_id_ff) ?
                     cmd_data.id - prev_id_ff - 1'b1 : '0;
   assign drop_sum = SUM_W'(drop_ff) + SUM_W'(gap);
   assign byte_sum = (BYTE_TOTAL_W+1)'(byte_total_ff) + (BYTE_TOTAL_W+1)'(cmd_data.bytes);
   assign take     = ~cmd_status.empty & ~rsp_valid_ff;

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      incomp_in     = incomp_ff;
      drop_in       = drop_ff;
      prev_id_in    = prev_id_ff;
      stamp_in      = stamp_ff;
      rate_in       = rate_ff;
      tput_in       = tput_ff;
      first_time_in = first_time_ff;
      prev_time_in  = prev_time_ff;
      byte_total_in = byte_total_ff;
      seen_first_in = seen_first_ff;
      dt_in         = dt_ff;
      cur_bytes_in  = cur_bytes_ff;
      rsp_valid_in  = rsp_valid_ff & ~pop;
      cmd_pop       = 1'b0;
      ratio_ctl     = '0;
      ratio_operand = '0;
      case (state_ff)
         B_IDLE: begin
            if (take) begin
               cmd_pop  = 1'b1;
               state_in = B_EMIT;
               case (cmd_data.kind)
                  CMD_CLEAR: begin
                     total_in      = '0;
                     incomp_in     = '0;
                     drop_in       = '0;
                     prev_id_in    = '0;
                     stamp_in      = '0;
                     rate_in       = '0;
                     tput_in       = '0;
                     first_time_in = '0;
                     prev_time_in  = '0;
                     byte_total_in = '0;
                     seen_first_in = 1'b0;
                  end
                  CMD_INCOMPLETE: begin
                     incomp_in = (incomp_ff == '1) ? incomp_ff : incomp_ff + 1'b1;
                  end
                  CMD_FRAME: begin
                     total_in   = (total_ff == '1) ? total_ff : total_ff + 1'b1;
                     stamp_in   = cmd_data.stamp;
                     drop_in    = ((drop_sum >> COUNT_BITS) != '0) ? '1 :
                                  drop_sum[COUNT_BITS-1:0];
                     prev_id_in = cmd_data.id;
                     if (!seen_first_ff) begin
                        seen_first_in = 1'b1;
                        first_time_in = cmd_data.now;
                        prev_time_in  = cmd_data.now;
                     end else begin
                        cur_bytes_in = cmd_data.bytes;
                        state_in     = B_RATE;
                        if (average_mode) begin
                           dt_in         = cmd_data.now - first_time_ff;
                           byte_total_in = byte_sum[BYTE_TOTAL_W] ? '1 :
                                           byte_sum[BYTE_TOTAL_W-1:0];
                        end else begin
                           dt_in        = cmd_data.now - prev_time_ff;
                           prev_time_in = cmd_data.now;
                        end
                     end
                  end
                  default: begin
                     state_in = B_EMIT;
                  end
               endcase
            end
         end
         // frames over the interval, times 10^8 per microsecond
         B_RATE: begin
            ratio_ctl.start = 1'b1;
            ratio_operand   = average_mode ? OPW'(total_ff - 1'b1) : OPW'(1);
            state_in        = B_RATE_WAIT;
         end
         B_RATE_WAIT: begin
            if (ratio_done) begin
               rate_in  = ratio_quo;
               state_in = B_TPUT;
            end
         end
         // bytes over the interval, times 800 per microsecond
         B_TPUT: begin
            ratio_ctl.start          = 1'b1;
            ratio_ctl.use_bits_scale = 1'b1;
            ratio_operand = average_mode ? OPW'(byte_total_ff) : OPW'(cur_bytes_ff);
            state_in      = B_TPUT_WAIT;
         end
         B_TPUT_WAIT: begin
            if (ratio_done) begin
               tput_in  = ratio_quo;
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            rsp_valid_in = 1'b1;
            state_in     = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign ratio_den = dt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         total_ff      <= '0;
         incomp_ff     <= '0;
         drop_ff       <= '0;
         prev_id_ff    <= '0;
         stamp_ff      <= '0;
         rate_ff       <= '0;
         tput_ff       <= '0;
         first_time_ff <= '0;
         prev_time_ff  <= '0;
         byte_total_ff <= '0;
         seen_first_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         incomp_ff     <= incomp_in;
         drop_ff       <= drop_in;
         prev_id_ff    <= prev_id_in;
         stamp_ff      <= stamp_in;
         rate_ff       <= rate_in;
         tput_ff       <= tput_in;
         first_time_ff <= first_time_in;
         prev_time_ff  <= prev_time_in;
         byte_total_ff <= byte_total_in;
         seen_first_ff <= seen_first_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      dt_ff        <= dt_in;
      cur_bytes_ff <= cur_bytes_in;
      // result register, loaded from the updated statistics
      if (state_ff == B_EMIT) begin
         rsp_total_ff  <= OUT_W'(total_ff);
         rsp_incomp_ff <= OUT_W'(incomp_ff);
         rsp_drop_ff   <= OUT_W'(drop_ff);
         rsp_id_ff     <= prev_id_ff;
         rsp_stamp_ff  <= stamp_ff;
         rsp_rate_ff   <= rate_ff;
         rsp_tput_ff   <= tput_ff;
      end
   end

   assign empty                 = ~rsp_valid_ff;
   assign rsp_frames_total      = rsp_total_ff;
   assign rsp_frames_incomplete = rsp_incomp_ff;
   assign rsp_frames_dropped    = rsp_drop_ff;
   assign rsp_last_id           = rsp_id_ff;
   assign rsp_last_stamp        = rsp_stamp_ff;
   assign rsp_rate_x100         = rsp_rate_ff;
   assign rsp_throughput_x100   = rsp_tput_ff;

   // result register is only loaded while it is free
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EMIT) |-> !rsp_valid_ff)
      else $error("result loaded over an unread transaction");

   // a new result appears only out of the emit step
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_EMIT))
      else $error("result valid without emit");

   // the total count only goes down through a clear command
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      (total_ff < $past(total_ff)) |-> $past(cmd_pop && cmd_data.kind == CMD_CLEAR))
      else $error("frame total decreased without clear");

   // no rate is known before the first complete frame
   a_rate_zero_before_first: assert property (@(posedge clock) disable iff (reset)
      !seen_first_ff |-> (rate_ff == '0 && tput_ff == '0))
      else $error("rate set before first frame");

endmodule
